// File: design/pse_pkg.sv
// ============================================================================
// pse_pkg
// Shared types and constants for the protobuf scalar field encoder.
// ============================================================================
`default_nettype none

package pse_pkg;

    localparam int FNUM_W    = 29;
    localparam int FTYPE_W   = 4;
    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int SEPT_W    = 7;   // payload bits per varint byte
    localparam int TAG_SHIFT = 3;
    localparam int TAG_W     = FNUM_W + TAG_SHIFT;
    localparam int REM_W     = 3;   // counts remaining fixed bytes, up to 7

    // Field type codes
    localparam logic [FTYPE_W-1:0] TYPE_INT64    = 4'd0;
    localparam logic [FTYPE_W-1:0] TYPE_UINT64   = 4'd1;
    localparam logic [FTYPE_W-1:0] TYPE_INT32    = 4'd2;
    localparam logic [FTYPE_W-1:0] TYPE_UINT32   = 4'd3;
    localparam logic [FTYPE_W-1:0] TYPE_ENUM     = 4'd4;
    localparam logic [FTYPE_W-1:0] TYPE_BOOL     = 4'd5;
    localparam logic [FTYPE_W-1:0] TYPE_FIXED64  = 4'd6;
    localparam logic [FTYPE_W-1:0] TYPE_SFIXED64 = 4'd7;
    localparam logic [FTYPE_W-1:0] TYPE_FIXED32  = 4'd8;
    localparam logic [FTYPE_W-1:0] TYPE_SFIXED32 = 4'd9;
    localparam logic [FTYPE_W-1:0] TYPE_SINT32   = 4'd10;
    localparam logic [FTYPE_W-1:0] TYPE_SINT64   = 4'd11;

    // Wire types
    localparam logic [TAG_SHIFT-1:0] WIRE_VARINT = 3'd0;
    localparam logic [TAG_SHIFT-1:0] WIRE_FIX64  = 3'd1;
    localparam logic [TAG_SHIFT-1:0] WIRE_FIX32  = 3'd5;

    // Fixed payload byte counts, minus one
    localparam logic [REM_W-1:0] FIX64_REM = 3'd7;
    localparam logic [REM_W-1:0] FIX32_REM = 3'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAG,
        ST_PAY
    } pse_state_t;

    typedef struct packed {
        logic load;
        logic emit_tag;
        logic emit_pay;
    } pse_cmd_t;

    typedef struct packed {
        logic skip;
        logic tag_more;
        logic pay_more;
    } pse_sts_t;

endpackage

`default_nettype wire

// File: design/pse_dp.sv
// ============================================================================
// pse_dp
// Datapath: input decode, tag and payload shift registers, output byte reg.
// ============================================================================
`default_nettype none

module pse_dp (
    input  wire                          clk,
    input  wire  [pse_pkg::FNUM_W-1:0]   field_number,
    input  wire  [pse_pkg::FTYPE_W-1:0]  field_type,
    input  wire                          is_repeated,
    input  wire  [pse_pkg::WORD_W-1:0]   value_low,
    input  wire  [pse_pkg::WORD_W-1:0]   value_high,
    input  wire  [pse_pkg::WORD_W-1:0]   default_low,
    input  wire  [pse_pkg::WORD_W-1:0]   default_high,
    input  wire  pse_pkg::pse_cmd_t      cmd,
    output pse_pkg::pse_sts_t            sts,
    output logic [pse_pkg::BYTE_W-1:0]   out_byte,
    output logic                         last_byte
);
    import pse_pkg::*;

    localparam int PAY_W = 2 * WORD_W;

    logic [TAG_SHIFT-1:0] wire_type;
    logic [TAG_W-1:0]     tag_load;
    logic [PAY_W-1:0]     pay_load;
    logic [PAY_W-1:0]     v64;
    logic [WORD_W-1:0]    zz32;
    logic [PAY_W-1:0]     zz64;
    logic                 fixed_load;
    logic [REM_W-1:0]     rem_load;
    logic                 unknown_type;
    logic                 same_low;
    logic                 same_high;
    logic                 skip;

    logic [TAG_W-1:0]     tag_reg,   tag_next;
    logic [PAY_W-1:0]     pay_reg,   pay_next;
    logic                 fixed_reg, fixed_next;
    logic [REM_W-1:0]     rem_reg,   rem_next;
    logic [BYTE_W-1:0]    byte_reg,  byte_next;
    logic                 last_reg,  last_next;

    logic                 tag_more;
    logic                 pay_more;

    // Input decode
    always_comb
    begin
        v64  = {value_high, value_low};
        zz32 = {value_low[WORD_W-2:0], 1'b0} ^ {WORD_W{value_low[WORD_W-1]}};
        zz64 = {v64[PAY_W-2:0], 1'b0} ^ {PAY_W{v64[PAY_W-1]}};

        wire_type  = WIRE_VARINT;
        pay_load   = v64;
        fixed_load = 1'b0;
        rem_load   = '0;
        unique case (field_type) inside
            TYPE_INT64, TYPE_UINT64, TYPE_INT32:
            begin
                pay_load = v64;
            end
            TYPE_UINT32, TYPE_ENUM, TYPE_BOOL:
            begin
                pay_load = {{WORD_W{1'b0}}, value_low};
            end
            TYPE_FIXED64, TYPE_SFIXED64:
            begin
                wire_type  = WIRE_FIX64;
                fixed_load = 1'b1;
                rem_load   = FIX64_REM;
            end
            TYPE_FIXED32, TYPE_SFIXED32:
            begin
                wire_type  = WIRE_FIX32;
                pay_load   = {{WORD_W{1'b0}}, value_low};
                fixed_load = 1'b1;
                rem_load   = FIX32_REM;
            end
            TYPE_SINT32:
            begin
                pay_load = {{WORD_W{1'b0}}, zz32};
            end
            TYPE_SINT64:
            begin
                pay_load = zz64;
            end
            default:
            begin
                pay_load = v64;
            end
        endcase
        tag_load = {field_number, wire_type};

        unknown_type = (field_type > TYPE_SINT64);
        same_low     = (value_low == default_low);
        same_high    = (value_high == default_high);
        // enum compares the low word only
        skip = unknown_type ||
               (!is_repeated && same_low && (same_high || field_type == TYPE_ENUM));
    end

    assign tag_more = |tag_reg[TAG_W-1:SEPT_W];
    assign pay_more = fixed_reg ? (rem_reg != '0) : |pay_reg[PAY_W-1:SEPT_W];
    assign sts      = {skip, tag_more, pay_more};

    always_comb
    begin
        tag_next   = tag_reg;
        pay_next   = pay_reg;
        fixed_next = fixed_reg;
        rem_next   = rem_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (cmd.load)
        begin
            tag_next   = tag_load;
            pay_next   = pay_load;
            fixed_next = fixed_load;
            rem_next   = rem_load;
        end
        else if (cmd.emit_tag)
        begin
            byte_next = {tag_more, tag_reg[SEPT_W-1:0]};
            last_next = 1'b0;
            tag_next  = tag_reg >> SEPT_W;
        end
        else if (cmd.emit_pay)
        begin
            last_next = !pay_more;
            if (fixed_reg)
            begin
                byte_next = pay_reg[BYTE_W-1:0];
                pay_next  = pay_reg >> BYTE_W;
                rem_next  = rem_reg - 1'b1;
            end
            else
            begin
                byte_next = {pay_more, pay_reg[SEPT_W-1:0]};
                pay_next  = pay_reg >> SEPT_W;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        pay_reg   <= pay_next;
        fixed_reg <= fixed_next;
        rem_reg   <= rem_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign out_byte  = byte_reg;
    assign last_byte = last_reg;

endmodule

`default_nettype wire

// File: design/pse_ctrl.sv
// ============================================================================
// pse_ctrl
// Controller: sequences tag bytes then payload bytes, owns the handshakes.
// ============================================================================
`default_nettype none

module pse_ctrl (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire                       out_ready,
    input  wire  pse_pkg::pse_sts_t   sts,
    output pse_pkg::pse_cmd_t         cmd
);
    import pse_pkg::*;

    pse_state_t state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       slot_free;

    // output register can take a byte this cycle
    assign slot_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !sts.skip)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TAG;
                end
            end
            ST_TAG:
            begin
                if (slot_free)
                begin
                    cmd.emit_tag = 1'b1;
                    if (!sts.tag_more)
                    begin
                        state_next = ST_PAY;
                    end
                end
            end
            ST_PAY:
            begin
                if (slot_free)
                begin
                    cmd.emit_pay = 1'b1;
                    if (!sts.pay_more)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit_tag || cmd.emit_pay)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// File: design/protobuf_scalar_field_encoder.sv
// ============================================================================
// protobuf_scalar_field_encoder
// Encodes one integer-valued protobuf field into its wire bytes.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one field per transfer: field
//   number, type code, repeated flag, 64-bit value and 64-bit default.
//   Output channel (out_valid/out_ready) carries one wire byte per transfer,
//   tag varint first, then the payload; last_byte marks the final byte.
//   A non-repeated field equal to its default, or an unknown type code,
//   is consumed and produces no output transfer.
// Timing:
//   The input transfer loads the field, then the controller emits one byte per
//   cycle into the output register whenever that register is free to take it.
//   A field has at most 15 bytes: 5 tag bytes plus 10 varint bytes. The first
//   byte enters the output register from the tag state, after the load.
//   The next field is accepted as soon as the last byte sits in the output
//   register.
// Stall:
//   While out_ready is low the output register holds its byte and the
//   sequencer waits; nothing is dropped.
// Reset:
//   rst_n clears the sequencer to idle and drops out_valid; in_ready is high
//   right after reset.
// ============================================================================
`default_nettype none

module protobuf_scalar_field_encoder (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [pse_pkg::FNUM_W-1:0]   field_number,
    input  wire  [pse_pkg::FTYPE_W-1:0]  field_type,
    input  wire                          is_repeated,
    input  wire  [pse_pkg::WORD_W-1:0]   value_low,
    input  wire  [pse_pkg::WORD_W-1:0]   value_high,
    input  wire  [pse_pkg::WORD_W-1:0]   default_low,
    input  wire  [pse_pkg::WORD_W-1:0]   default_high,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [pse_pkg::BYTE_W-1:0]   out_byte,
    output logic                         last_byte
);
    import pse_pkg::*;

    pse_cmd_t cmd;   // controller -> datapath
    pse_sts_t sts;   // datapath -> controller

    // Sequencer: idle / tag bytes / payload bytes, plus output valid flag
    pse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Decode, shift registers and output byte register
    pse_dp u_dp (
        .clk          (clk),
        .field_number (field_number),
        .field_type   (field_type),
        .is_repeated  (is_repeated),
        .value_low    (value_low),
        .value_high   (value_high),
        .default_low  (default_low),
        .default_high (default_high),
        .cmd          (cmd),
        .sts          (sts),
        .out_byte     (out_byte),
        .last_byte    (last_byte)
    );

endmodule

`default_nettype wire

// File: design/pse_chk.sv
// ============================================================================
// pse_chk
// Port-level checks for the protobuf scalar field encoder.
// ============================================================================
`default_nettype none

module pse_chk (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_valid,
    input wire                          in_ready,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire [pse_pkg::BYTE_W-1:0]    out_byte,
    input wire                          last_byte
);
    import pse_pkg::*;

    // stalled output byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
        else $error("output byte changed under stall");

    // a pending non-final byte means the field is still in progress
    a_busy_mid_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_byte |-> !in_ready)
        else $error("input taken in the middle of a field");

    // returning to idle only happens with the final byte loaded
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid && last_byte)
        else $error("ready again without a final byte");

    // idle with an empty output: no byte appears before a field is loaded
    a_no_byte_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !out_valid |=> !out_valid)
        else $error("byte appeared without a loaded field");

endmodule

bind protobuf_scalar_field_encoder pse_chk u_pse_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
);

`default_nettype wire
